/* src/cpf_pkg.sv */
package cpf_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // operation codes carried through the queue
    localparam logic [1:0] OP_DATA     = 2'd0;  // one decoded byte
    localparam logic [1:0] OP_DATA_END = 2'd1;  // decoded byte, then frame report
    localparam logic [1:0] OP_END      = 2'd2;  // frame report only

    // configuration register indexes
    localparam logic CFG_STATION_ADDR = 1'b0;
    localparam logic CFG_NOP_COMMAND  = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_LENGTH_ERR = 3'd1;
    localparam logic [2:0] ST_BAD_SUM    = 3'd2;
    localparam logic [2:0] ST_LOOPBACK   = 3'd3;
    localparam logic [2:0] ST_OTHER_DEST = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
    localparam logic [7:0] COBS_MAX_CODE = 8'hFF;
    localparam logic [7:0] MAX_INDEX     = 8'hFF;
    localparam logic [7:0] BCAST_ADDR    = 8'h00;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [7:0] source_addr;
        logic [7:0] dst_addr;
        logic [7:0] command_code;
        logic [7:0] payload_count;
        logic [2:0] frame_status;
        logic       is_broadcast;
        logic       command_known;
        logic       last;
    } t_result;

endpackage

/* src/cpf_front.sv */
module cpf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_line_byte,
    output logic          o_push,
    output cpf_pkg::t_op  o_op
);

    logic [7:0] r_group_left, n_group_left;
    logic [7:0] r_group_code, n_group_code;
    logic       r_zero_pending, n_zero_pending;

    always_comb begin
        n_group_left   = r_group_left;
        n_group_code   = r_group_code;
        n_zero_pending = r_zero_pending;
        o_push         = 1'b0;
        o_op.kind      = cpf_pkg::OP_DATA;
        o_op.data      = i_line_byte;
        if (i_accept) begin
            if (i_line_byte != 8'h00) begin
                if (r_group_left == 8'h00) begin
                    // code byte: owed zero goes out first
                    o_push         = r_zero_pending;
                    o_op.data      = 8'h00;
                    n_group_code   = i_line_byte;
                    n_group_left   = i_line_byte - 8'd1;
                    n_zero_pending = (i_line_byte != cpf_pkg::COBS_MAX_CODE);
                end else begin
                    o_push       = 1'b1;
                    n_group_left = r_group_left - 8'd1;
                end
            end else begin
                // delimiter; an empty frame gives nothing
                if (r_group_code != 8'h00) begin
                    o_push    = 1'b1;
                    o_op.data = r_group_code;
                    // truncated final group: code byte is the last decoded byte
                    o_op.kind = (r_group_left != 8'h00) ? cpf_pkg::OP_DATA_END
                                                        : cpf_pkg::OP_END;
                end
                n_group_left   = 8'h00;
                n_group_code   = 8'h00;
                n_zero_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_left   <= 8'h00;
            r_group_code   <= 8'h00;
            r_zero_pending <= 1'b0;
        end else begin
            r_group_left   <= n_group_left;
            r_group_code   <= n_group_code;
            r_zero_pending <= n_zero_pending;
        end
    end

endmodule

/* src/cpf_queue.sv */
module cpf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cpf_pkg::t_op  i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output cpf_pkg::t_op  o_data
);

    cpf_pkg::t_op                r_mem [cpf_pkg::Q_DEPTH];
    logic [cpf_pkg::Q_AW-1:0]    r_wr, r_rd;
    logic [cpf_pkg::Q_CW-1:0]    r_count;

    assign o_full  = (r_count == cpf_pkg::Q_CW'(cpf_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + cpf_pkg::Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + cpf_pkg::Q_AW'(1);
            end
            r_count <= r_count + cpf_pkg::Q_CW'(i_push) - cpf_pkg::Q_CW'(i_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cpf_pkg::Q_CW'(cpf_pkg::Q_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0) && !(i_push && o_full))
        else $error("queue pop while empty or push while full");

endmodule

/* src/cpf_back.sv */
module cpf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_station_addr,
    input  logic [7:0]        i_nop_command_code,
    input  logic              i_q_valid,
    input  cpf_pkg::t_op      i_q_op,
    output logic              o_q_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output cpf_pkg::t_result  o_out
);

    logic             r_phase;
    logic [7:0]       r_index;
    logic [7:0]       r_length;
    logic [7:0]       r_source;
    logic [7:0]       r_dest;
    logic [7:0]       r_command;
    logic [7:0]       r_sum;
    logic [7:0]       r_recv_sum;
    logic             r_out_valid;
    cpf_pkg::t_result r_out;

    logic       adv, act, do_decode, do_report;
    logic [7:0] len_now;
    logic [8:0] idx_p1;
    logic       sat, sum_it, recv_it, emit;
    logic [2:0] status;
    cpf_pkg::t_result rep, pay;

    assign adv = !r_out_valid || i_out_ready;
    assign act = i_q_valid && adv;

    assign do_decode = (i_q_op.kind == cpf_pkg::OP_DATA) ||
                       ((i_q_op.kind == cpf_pkg::OP_DATA_END) && !r_phase);
    assign do_report = (i_q_op.kind == cpf_pkg::OP_END) ||
                       ((i_q_op.kind == cpf_pkg::OP_DATA_END) && r_phase);

    assign o_q_pop = act && ((i_q_op.kind != cpf_pkg::OP_DATA_END) || r_phase);

    // decoded byte bookkeeping
    assign sat     = (r_index == cpf_pkg::MAX_INDEX);
    assign len_now = (r_index == 8'd0) ? i_q_op.data : r_length;
    assign idx_p1  = {1'b0, r_index} + 9'd1;
    assign sum_it  = !sat && (idx_p1 < {1'b0, len_now});
    assign recv_it = !sat && (idx_p1 == {1'b0, len_now});
    assign emit    = sum_it && (r_index >= 8'd4);

    always_comb begin
        if (r_length < cpf_pkg::MIN_FRAME_LEN || r_index != r_length) begin
            status = cpf_pkg::ST_LENGTH_ERR;
        end else if (r_recv_sum != r_sum) begin
            status = cpf_pkg::ST_BAD_SUM;
        end else if (r_source == i_station_addr) begin
            status = cpf_pkg::ST_LOOPBACK;
        end else if (r_dest != i_station_addr && r_dest != cpf_pkg::BCAST_ADDR) begin
            status = cpf_pkg::ST_OTHER_DEST;
        end else begin
            status = cpf_pkg::ST_ACCEPTED;
        end
    end

    always_comb begin
        rep               = '0;
        rep.item_kind     = cpf_pkg::KIND_REPORT;
        rep.source_addr   = r_source;
        rep.dst_addr      = r_dest;
        rep.command_code  = r_command;
        rep.payload_count = (status == cpf_pkg::ST_LENGTH_ERR) ? 8'd0
                                                               : r_length - cpf_pkg::MIN_FRAME_LEN;
        rep.frame_status  = status;
        rep.is_broadcast  = (status == cpf_pkg::ST_ACCEPTED) &&
                            (r_dest == cpf_pkg::BCAST_ADDR) && (i_station_addr != 8'd0);
        rep.command_known = (r_command == i_nop_command_code);
        rep.last          = 1'b1;

        pay               = '0;
        pay.item_kind     = cpf_pkg::KIND_PAYLOAD;
        pay.payload_byte  = i_q_op.data;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= do_report ? rep : pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_index     <= 8'd0;
            r_length    <= 8'd0;
            r_source    <= 8'd0;
            r_dest      <= 8'd0;
            r_command   <= 8'd0;
            r_sum       <= 8'd0;
            r_recv_sum  <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= act && (do_report || (do_decode && emit));
            end
            if (act && i_q_op.kind == cpf_pkg::OP_DATA_END) begin
                r_phase <= !r_phase;
            end
            if (act && do_report) begin
                r_index    <= 8'd0;
                r_length   <= 8'd0;
                r_source   <= 8'd0;
                r_dest     <= 8'd0;
                r_command  <= 8'd0;
                r_sum      <= 8'd0;
                r_recv_sum <= 8'd0;
            end else if (act && do_decode) begin
                if (sat) begin
                    // overlong frame forces a length error
                    r_length <= 8'd0;
                end else begin
                    case (r_index)
                        8'd0:    r_length  <= i_q_op.data;
                        8'd1:    r_source  <= i_q_op.data;
                        8'd2:    r_dest    <= i_q_op.data;
                        8'd3:    r_command <= i_q_op.data;
                        default: ;
                    endcase
                    if (sum_it) begin
                        r_sum <= r_sum + i_q_op.data;
                    end else if (recv_it) begin
                        r_recv_sum <= i_q_op.data;
                    end
                    r_index <= idx_p1[7:0];
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_q_valid && (i_q_op.kind == cpf_pkg::OP_DATA_END))
        else $error("second step without a pending end operation");

endmodule

/* src/cobsr_packet_receive_filter.sv */
// path: a line byte's operation is written into the queue, and the result word is then registered in the back end
// throughput: one line byte per cycle while the queue has room; a delimiter that closes
//   a truncated final group needs a back-end step for its code byte, then one for the report
// the four-entry queue between decoder and checker absorbs that extra step and output stalls
// reset: synchronous, active low; clears decoder, queue, frame state and output valid,
//   and sets the station address to 1 and the no-operation code to 0
module cobsr_packet_receive_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // line byte input
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_line_byte,
    // result output
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_item_kind,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_source_addr,
    output logic [7:0] o_dst_addr,
    output logic [7:0] o_command_code,
    output logic [7:0] o_payload_count,
    output logic [2:0] o_frame_status,
    output logic       o_is_broadcast,
    output logic       o_command_known,
    output logic       o_last,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // configuration registers
    logic [7:0] r_station_addr;
    logic [7:0] r_nop_command_code;

    logic             accept;
    logic             q_full;
    logic             push;
    cpf_pkg::t_op     push_op;
    logic             q_valid;
    cpf_pkg::t_op     q_op;
    logic             q_pop;
    cpf_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_addr     <= 8'd1;
            r_nop_command_code <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cpf_pkg::CFG_STATION_ADDR: r_station_addr     <= i_cfg_data;
                cpf_pkg::CFG_NOP_COMMAND:  r_nop_command_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the front takes a word whenever the queue has room, even if it yields no operation
    assign o_ready = !q_full;
    assign accept  = i_valid && !q_full;

    // front: cobs/r group tracking, turns line words into decoded-byte and report operations
    cpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_line_byte (i_line_byte),
        .o_push      (push),
        .o_op        (push_op)
    );

    cpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_op)
    );

    // back: header capture, running sum, frame checks and the output register
    cpf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_station_addr     (r_station_addr),
        .i_nop_command_code (r_nop_command_code),
        .i_q_valid          (q_valid),
        .i_q_op             (q_op),
        .o_q_pop            (q_pop),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_out              (res)
    );

    assign o_item_kind     = res.item_kind;
    assign o_payload_byte  = res.payload_byte;
    assign o_source_addr   = res.source_addr;
    assign o_dst_addr      = res.dst_addr;
    assign o_command_code  = res.command_code;
    assign o_payload_count = res.payload_count;
    assign o_frame_status  = res.frame_status;
    assign o_is_broadcast  = res.is_broadcast;
    assign o_command_known = res.command_known;
    assign o_last          = res.last;

    // a report always closes the frame, a payload word never does
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == o_item_kind))
        else $error("last flag disagrees with word kind");

    // broadcast only flagged on an accepted frame to address zero
    a_bcast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_broadcast) |->
            (o_frame_status == cpf_pkg::ST_ACCEPTED) && (o_dst_addr == cpf_pkg::BCAST_ADDR))
        else $error("broadcast flag on a frame that was not accepted");

endmodule
